### sv/json_stream_indenter_unit_assert.svh
// Assertion macros shared by the indenter RTL.
`ifndef JSON_STREAM_INDENTER_UNIT_ASSERT_SVH
`define JSON_STREAM_INDENTER_UNIT_ASSERT_SVH

// cond must hold at every edge out of reset
`define JSI_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// cons must hold in the same cycle as ante
`define JSI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// cons must hold in the cycle after ante
`define JSI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/jsi_pkg.sv
// Types and character constants for the JSON stream indenter.
`default_nettype none
package jsi_pkg;

	typedef logic [7:0] byte_t;

	localparam byte_t CH_SPACE  = 8'h20;
	localparam byte_t CH_NL     = 8'h0A;
	localparam byte_t CH_BSLASH = 8'h5C;
	localparam byte_t CH_QUOTE  = 8'h22;
	localparam byte_t CH_LBRACE = 8'h7B;
	localparam byte_t CH_LBRACK = 8'h5B;
	localparam byte_t CH_RBRACE = 8'h7D;
	localparam byte_t CH_RBRACK = 8'h5D;
	localparam byte_t CH_COMMA  = 8'h2C;
	localparam byte_t CH_COLON  = 8'h3A;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEAD0,
		PH_HEAD1,
		PH_INDENT,
		PH_TAIL
	} phase_t;

	typedef struct packed {
		byte_t h0;
		byte_t h1;
		byte_t tail;
		logic  has_h1;
		logic  has_tail;
		logic  sat;
	} run_t;

endpackage
`default_nettype wire

### sv/jsi_in_if.sv
// Input byte channel of the JSON stream indenter.
`default_nettype none
interface jsi_in_if;
	logic valid;
	logic ready;
	logic [7:0] in_char;

	modport source (output valid, output in_char, input ready);
	modport sink (input valid, input in_char, output ready);
endinterface
`default_nettype wire

### sv/jsi_out_if.sv
// Output byte channel of the JSON stream indenter.
`default_nettype none
interface jsi_out_if;
	logic valid;
	logic ready;
	logic [7:0] out_char;
	logic run_last;
	logic depth_saturated;

	modport source (output valid, output out_char, output run_last,
		output depth_saturated, input ready);
	modport sink (input valid, input out_char, input run_last,
		input depth_saturated, output ready);
endinterface
`default_nettype wire

### sv/jsi_parse.sv
// Lexical state tracker: string, escape, nesting depth and run descriptor.
`default_nettype none
`include "json_stream_indenter_unit_assert.svh"
module jsi_parse #(
	parameter int MAX_DEPTH = 30,
	parameter int DepthW    = 6
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 take,
	input  wire  [7:0]          ch,
	output jsi_pkg::run_t       run,
	output logic [DepthW-1:0]   indent_cnt
);

	localparam logic signed [DepthW-1:0] DepMax = DepthW'(MAX_DEPTH);
	localparam logic signed [DepthW-1:0] DepMin = -DepMax;

	logic signed [DepthW-1:0] depth_q, depth_d;
	logic                     in_str_q, in_str_d;
	logic                     esc_q, esc_d;
	logic                     sat_q, sat_d;
	logic signed [DepthW-1:0] indent_depth;

	always_comb begin
		depth_d       = depth_q;
		in_str_d      = in_str_q;
		esc_d         = esc_q;
		sat_d         = sat_q;
		run.h0        = ch;
		run.h1        = jsi_pkg::CH_NL;
		run.tail      = ch;
		run.has_h1    = 1'b0;
		run.has_tail  = 1'b0;
		indent_depth  = '0;
		if (in_str_q) begin
			if (esc_q) begin
				esc_d = 1'b0;
			end else if (ch == jsi_pkg::CH_BSLASH) begin
				esc_d = 1'b1;
			end else if (ch == jsi_pkg::CH_QUOTE) begin
				in_str_d = 1'b0;
			end
		end else begin
			case (ch)
				jsi_pkg::CH_QUOTE: begin
					in_str_d = 1'b1;
				end
				jsi_pkg::CH_LBRACE, jsi_pkg::CH_LBRACK: begin
					run.has_h1 = 1'b1;
					if (depth_q == DepMax) begin
						sat_d = 1'b1;
					end else begin
						depth_d = depth_q + DepthW'(1);
					end
					indent_depth = depth_d;
				end
				jsi_pkg::CH_RBRACE, jsi_pkg::CH_RBRACK: begin
					run.h0       = jsi_pkg::CH_NL;
					run.has_tail = 1'b1;
					if (depth_q == DepMin) begin
						sat_d = 1'b1;
					end else begin
						depth_d = depth_q - DepthW'(1);
					end
					indent_depth = depth_d;
				end
				jsi_pkg::CH_COMMA: begin
					run.has_h1   = 1'b1;
					indent_depth = depth_q;
				end
				jsi_pkg::CH_COLON: begin
					run.h1     = jsi_pkg::CH_SPACE;
					run.has_h1 = 1'b1;
				end
				default: begin
				end
			endcase
		end
		run.sat = sat_d;
	end

	assign indent_cnt = (!indent_depth[DepthW-1] && indent_depth != '0) ?
		{indent_depth[DepthW-2:0], 1'b0} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q  <= '0;
			in_str_q <= 1'b0;
			esc_q    <= 1'b0;
			sat_q    <= 1'b0;
		end else if (take) begin
			depth_q  <= depth_d;
			in_str_q <= in_str_d;
			esc_q    <= esc_d;
			sat_q    <= sat_d;
		end
	end

	`JSI_ASSERT_ALWAYS(a_depth_range, (depth_q <= DepMax) && (depth_q >= DepMin), "depth out of range")
	`JSI_ASSERT_NOW(a_esc_in_str, esc_q, in_str_q, "escape pending outside a string")
	`JSI_ASSERT_NEXT(a_sat_sticky, sat_q, sat_q, "saturation flag cleared")

endmodule
`default_nettype wire

### sv/json_stream_indenter_unit.sv
// JSON stream indenter top level: takes one byte, emits its re-indented run.
// Each accepted input byte is expanded into an output run of n bytes: 1 for
// plain bytes, 2 for a colon and 2 + 2*depth for braces, brackets and commas
// (62 at most with MAX_DEPTH = 30). A small sequencer walks the run through
// head, indent and tail phases with one down-counter, emitting one word per
// cycle into an output register; the input is ready only while that sequencer
// is idle. Output back-pressure holds the sequencer on its current word.
`default_nettype none
`include "json_stream_indenter_unit_assert.svh"
module json_stream_indenter_unit #(
	parameter int MAX_DEPTH = 30
) (
	input wire         clk,
	input wire         arst_n,
	jsi_in_if.sink     in_stream,
	jsi_out_if.source  out_stream
);

	localparam int DepthW = $clog2(MAX_DEPTH + 1) + 1;

	jsi_pkg::phase_t   phase_q, phase_d;
	jsi_pkg::run_t     run_q, run_new;
	logic [DepthW-1:0] cnt_q, cnt_d, cnt_new;
	logic              take;
	logic              out_free;
	logic              emit;
	logic              emit_last;
	jsi_pkg::byte_t    emit_byte;
	logic              out_valid_q;
	jsi_pkg::byte_t    out_char_q;
	logic              out_last_q;
	logic              out_sat_q;

	assign in_stream.ready = (phase_q == jsi_pkg::PH_IDLE);
	assign take            = in_stream.valid && in_stream.ready;
	assign out_free        = !out_valid_q || out_stream.ready;

	jsi_parse #(
		.MAX_DEPTH (MAX_DEPTH),
		.DepthW    (DepthW)
	) u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.ch         (in_stream.in_char),
		.run        (run_new),
		.indent_cnt (cnt_new)
	);

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		case (phase_q)
			jsi_pkg::PH_IDLE: begin
				if (take) begin
					phase_d = jsi_pkg::PH_HEAD0;
				end
			end
			jsi_pkg::PH_HEAD0: begin
				if (out_free) begin
					if (run_q.has_h1) begin
						phase_d = jsi_pkg::PH_HEAD1;
					end else if (cnt_q != '0) begin
						phase_d = jsi_pkg::PH_INDENT;
					end else if (run_q.has_tail) begin
						phase_d = jsi_pkg::PH_TAIL;
					end else begin
						phase_d = jsi_pkg::PH_IDLE;
					end
				end
			end
			jsi_pkg::PH_HEAD1: begin
				if (out_free) begin
					if (cnt_q != '0) begin
						phase_d = jsi_pkg::PH_INDENT;
					end else if (run_q.has_tail) begin
						phase_d = jsi_pkg::PH_TAIL;
					end else begin
						phase_d = jsi_pkg::PH_IDLE;
					end
				end
			end
			jsi_pkg::PH_INDENT: begin
				if (out_free) begin
					cnt_d = cnt_q - DepthW'(1);
					if (cnt_q == DepthW'(1)) begin
						phase_d = run_q.has_tail ? jsi_pkg::PH_TAIL : jsi_pkg::PH_IDLE;
					end
				end
			end
			jsi_pkg::PH_TAIL: begin
				if (out_free) begin
					phase_d = jsi_pkg::PH_IDLE;
				end
			end
			default: begin
				phase_d = jsi_pkg::PH_IDLE;
			end
		endcase
	end

	always_comb begin
		emit = (phase_q != jsi_pkg::PH_IDLE) && out_free;
		case (phase_q)
			jsi_pkg::PH_HEAD0:  emit_byte = run_q.h0;
			jsi_pkg::PH_HEAD1:  emit_byte = run_q.h1;
			jsi_pkg::PH_INDENT: emit_byte = jsi_pkg::CH_SPACE;
			jsi_pkg::PH_TAIL:   emit_byte = run_q.tail;
			default:            emit_byte = jsi_pkg::CH_SPACE;
		endcase
		emit_last = emit && (phase_d == jsi_pkg::PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= jsi_pkg::PH_IDLE;
			cnt_q   <= '0;
		end else begin
			phase_q <= phase_d;
			cnt_q   <= take ? cnt_new : cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			run_q <= run_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_stream.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_char_q <= emit_byte;
			out_last_q <= emit_last;
			out_sat_q  <= run_q.sat;
		end
	end

	assign out_stream.valid           = out_valid_q;
	assign out_stream.out_char        = out_char_q;
	assign out_stream.run_last        = out_last_q;
	assign out_stream.depth_saturated = out_sat_q;

	`JSI_ASSERT_NEXT(a_take_starts_run, take, phase_q == jsi_pkg::PH_HEAD0, "accepted byte did not start a run")
	`JSI_ASSERT_NOW(a_indent_live, phase_q == jsi_pkg::PH_INDENT, cnt_q != '0, "indent phase with empty count")
	`JSI_ASSERT_NEXT(a_last_ends_run, emit_last, phase_q == jsi_pkg::PH_IDLE, "run marked last but sequencer busy")

endmodule
`default_nettype wire

### test/json_stream_indenter_unit_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the JSON stream indenter, byte runs checked against a predictor.
module json_stream_indenter_unit_test;

	localparam int DEPTH_LIMIT = 30;

	typedef struct packed {
		jsi_pkg::byte_t ch;
		logic           last;
		logic           sat;
	} out_word_t;

	typedef struct packed {
		jsi_pkg::byte_t ch;
		logic [7:0]     n;
		logic [31:0]    run;
	} stim_row_t;

	logic clk;
	logic arst_n;
	jsi_in_if  in_ch();
	jsi_out_if out_ch();

	json_stream_indenter_unit #(.MAX_DEPTH(DEPTH_LIMIT)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_stream(in_ch),
		.out_stream(out_ch)
	);

	out_word_t pending_output[$];
	stim_row_t directed_rows[$];

	logic signed [5:0] nest_level = '0;
	logic str_open = 1'b0;
	logic after_escape = 1'b0;
	logic sat_seen = 1'b0;
	int peak_depth = 0;
	int low_depth = 0;
	int bytes_in = 0;
	int bytes_out = 0;
	int errors = 0;
	logic in_gaps = 1'b1;
	logic out_gaps = 1'b1;
	logic hold_off = 1'b0;
	logic pressure_go = 1'b0;

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int indent_spaces();
		return (nest_level > 0) ? 2 * nest_level : 0;
	endfunction

	// append one expected word to the tail of the queue
	function automatic void add_word(jsi_pkg::byte_t c, logic last, logic sat);
		out_word_t w;
		w.ch = c;
		w.last = last;
		w.sat = sat;
		pending_output = {pending_output, w};
	endfunction

	// predict the run for one byte, advance the tracked state, queue the run
	function automatic int format_byte(jsi_pkg::byte_t c);
		int base;
		int lv;
		int k;
		base = pending_output.size();
		if (str_open) begin
			add_word(c, 1'b0, 1'b0);
			if (after_escape)
				after_escape = 1'b0;
			else if (c == jsi_pkg::CH_BSLASH)
				after_escape = 1'b1;
			else if (c == jsi_pkg::CH_QUOTE)
				str_open = 1'b0;
		end else begin
			case (c)
				jsi_pkg::CH_QUOTE: begin
					str_open = 1'b1;
					add_word(c, 1'b0, 1'b0);
				end
				jsi_pkg::CH_LBRACE, jsi_pkg::CH_LBRACK: begin
					add_word(c, 1'b0, 1'b0);
					add_word(jsi_pkg::CH_NL, 1'b0, 1'b0);
					if (nest_level >= DEPTH_LIMIT)
						sat_seen = 1'b1;
					else
						nest_level = nest_level + 1;
					lv = indent_spaces();
					repeat (lv) add_word(jsi_pkg::CH_SPACE, 1'b0, 1'b0);
				end
				jsi_pkg::CH_RBRACE, jsi_pkg::CH_RBRACK: begin
					add_word(jsi_pkg::CH_NL, 1'b0, 1'b0);
					if (nest_level <= -DEPTH_LIMIT)
						sat_seen = 1'b1;
					else
						nest_level = nest_level - 1;
					lv = indent_spaces();
					repeat (lv) add_word(jsi_pkg::CH_SPACE, 1'b0, 1'b0);
					add_word(c, 1'b0, 1'b0);
				end
				jsi_pkg::CH_COMMA: begin
					add_word(c, 1'b0, 1'b0);
					add_word(jsi_pkg::CH_NL, 1'b0, 1'b0);
					lv = indent_spaces();
					repeat (lv) add_word(jsi_pkg::CH_SPACE, 1'b0, 1'b0);
				end
				jsi_pkg::CH_COLON: begin
					add_word(jsi_pkg::CH_COLON, 1'b0, 1'b0);
					add_word(jsi_pkg::CH_SPACE, 1'b0, 1'b0);
				end
				default: begin
					add_word(c, 1'b0, 1'b0);
				end
			endcase
		end
		if (nest_level > peak_depth)
			peak_depth = nest_level;
		if (nest_level < low_depth)
			low_depth = nest_level;
		for (k = base; k < pending_output.size(); k++) begin
			pending_output[k].sat = sat_seen;
			pending_output[k].last = (k == pending_output.size() - 1);
		end
		return pending_output.size() - base;
	endfunction

	task automatic note_mismatch(input string what, input int got, input int want);
		if (errors < 40)
			$display("%0t mismatch on %s: got %h, want %h", $time, what, got, want);
		errors++;
	endtask

	// hold valid until the word is taken, idling first at random
	task automatic deliver(input jsi_pkg::byte_t b);
		while (in_gaps && $urandom_range(0, 99) < 15) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.in_char <= b;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		bytes_in++;
	endtask

	task automatic feed_byte(input jsi_pkg::byte_t b);
		deliver(b);
		void'(format_byte(b));
	endtask

	function automatic jsi_pkg::byte_t opener();
		return $urandom_range(0, 1) ? jsi_pkg::CH_LBRACE : jsi_pkg::CH_LBRACK;
	endfunction

	function automatic jsi_pkg::byte_t closer();
		return $urandom_range(0, 1) ? jsi_pkg::CH_RBRACE : jsi_pkg::CH_RBRACK;
	endfunction

	task automatic feed_string();
		int len;
		jsi_pkg::byte_t b;
		len = $urandom_range(0, 6);
		feed_byte(jsi_pkg::CH_QUOTE);
		repeat (len) begin
			if ($urandom_range(0, 6) == 0) begin
				feed_byte(jsi_pkg::CH_BSLASH);
				feed_byte(jsi_pkg::byte_t'($urandom_range(0, 255)));
			end else begin
				b = jsi_pkg::byte_t'($urandom_range(8'h20, 8'h7E));
				if (b == jsi_pkg::CH_QUOTE || b == jsi_pkg::CH_BSLASH)
					b = 8'h78;
				feed_byte(b);
			end
		end
		feed_byte(jsi_pkg::CH_QUOTE);
	endtask

	task automatic feed_token();
		int pick;
		int len;
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			feed_byte(nest_level < 4 ? opener() : closer());
		end else if (pick < 24) begin
			feed_byte((nest_level > 0 || $urandom_range(0, 4) == 0) ? closer() : opener());
		end else if (pick < 36) begin
			feed_byte(jsi_pkg::CH_COMMA);
		end else if (pick < 46) begin
			feed_byte(jsi_pkg::CH_COLON);
		end else if (pick < 70) begin
			feed_string();
		end else if (pick < 85) begin
			len = $urandom_range(1, 4);
			repeat (len) feed_byte(jsi_pkg::byte_t'($urandom_range(8'h30, 8'h7A)));
		end else begin
			feed_byte(jsi_pkg::byte_t'($urandom_range(0, 255)));
		end
	endtask

	task automatic add_row(input jsi_pkg::byte_t ch, input int n, input logic [31:0] run);
		stim_row_t row;
		row.ch = ch;
		row.n = 8'(n);
		row.run = run;
		directed_rows = {directed_rows, row};
	endtask

	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			bytes_out++;
			if (pending_output.size() == 0) begin
				note_mismatch("unexpected word", out_ch.out_char, 0);
			end else begin
				want = pending_output.pop_front();
				if (out_ch.out_char !== want.ch)
					note_mismatch("out_char", out_ch.out_char, want.ch);
				if (out_ch.run_last !== want.last)
					note_mismatch("run_last", out_ch.run_last, want.last);
				if (out_ch.depth_saturated !== want.sat)
					note_mismatch("depth_saturated", out_ch.depth_saturated, want.sat);
			end
		end
		out_ch.ready <= !hold_off && !(out_gaps && $urandom_range(0, 99) < 15);
	end

	// long output stall so the block fills and holds off its input
	initial begin
		wait (pressure_go === 1'b1);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (300) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#20_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		stim_row_t row;
		int made;
		int i;
		in_ch.valid <= 1'b0;
		in_ch.in_char <= 8'h00;
		arst_n <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_row(8'h61, 1, {8'h61, 24'h0});
		add_row(8'h00, 1, 32'h0);
		add_row(8'hFF, 1, {8'hFF, 24'h0});
		add_row(jsi_pkg::CH_COLON, 2, {jsi_pkg::CH_COLON, jsi_pkg::CH_SPACE, 16'h0});
		add_row(jsi_pkg::CH_COMMA, 2, {jsi_pkg::CH_COMMA, jsi_pkg::CH_NL, 16'h0});
		add_row(jsi_pkg::CH_LBRACE, 4, {jsi_pkg::CH_LBRACE, jsi_pkg::CH_NL,
			jsi_pkg::CH_SPACE, jsi_pkg::CH_SPACE});
		add_row(jsi_pkg::CH_QUOTE, 1, {jsi_pkg::CH_QUOTE, 24'h0});
		add_row(jsi_pkg::CH_LBRACE, 1, {jsi_pkg::CH_LBRACE, 24'h0});
		add_row(jsi_pkg::CH_BSLASH, 1, {jsi_pkg::CH_BSLASH, 24'h0});
		add_row(jsi_pkg::CH_QUOTE, 1, {jsi_pkg::CH_QUOTE, 24'h0});
		add_row(jsi_pkg::CH_BSLASH, 1, {jsi_pkg::CH_BSLASH, 24'h0});
		add_row(jsi_pkg::CH_BSLASH, 1, {jsi_pkg::CH_BSLASH, 24'h0});
		add_row(jsi_pkg::CH_QUOTE, 1, {jsi_pkg::CH_QUOTE, 24'h0});
		add_row(jsi_pkg::CH_COLON, 2, {jsi_pkg::CH_COLON, jsi_pkg::CH_SPACE, 16'h0});
		add_row(jsi_pkg::CH_LBRACK, 0, 32'h0);
		add_row(jsi_pkg::CH_COMMA, 0, 32'h0);
		add_row(jsi_pkg::CH_RBRACK, 0, 32'h0);
		add_row(jsi_pkg::CH_RBRACE, 2, {jsi_pkg::CH_NL, jsi_pkg::CH_RBRACE, 16'h0});
		add_row(jsi_pkg::CH_RBRACK, 2, {jsi_pkg::CH_NL, jsi_pkg::CH_RBRACK, 16'h0});
		add_row(jsi_pkg::CH_COMMA, 2, {jsi_pkg::CH_COMMA, jsi_pkg::CH_NL, 16'h0});
		add_row(jsi_pkg::CH_LBRACK, 2, {jsi_pkg::CH_LBRACK, jsi_pkg::CH_NL, 16'h0});
		add_row(8'h55, 1, {8'h55, 24'h0});
		add_row(8'hAA, 1, {8'hAA, 24'h0});
		add_row(jsi_pkg::CH_QUOTE, 1, {jsi_pkg::CH_QUOTE, 24'h0});
		add_row(jsi_pkg::CH_QUOTE, 1, {jsi_pkg::CH_QUOTE, 24'h0});

		foreach (directed_rows[r]) begin
			row = directed_rows[r];
			deliver(row.ch);
			made = format_byte(row.ch);
			if (row.n != 0) begin
				repeat (made) void'(pending_output.pop_back());
				for (i = 0; i < row.n; i++)
					add_word(row.run[31 - 8 * i -: 8], i == row.n - 1, 1'b0);
			end
		end

		in_gaps = 1'b0;
		out_gaps <= 1'b0;
		while (bytes_in < 80)
			feed_token();
		in_gaps = 1'b1;
		out_gaps <= 1'b1;
		while (bytes_in < 100)
			feed_token();
		pressure_go <= 1'b1;
		while (bytes_in < 120)
			feed_token();

		// close any open string and rebalance before the deep dive
		if (str_open) begin
			if (after_escape)
				feed_byte(8'h78);
			feed_byte(jsi_pkg::CH_QUOTE);
		end
		while (nest_level > 0)
			feed_byte(closer());
		while (nest_level < 0)
			feed_byte(opener());

		for (i = 0; i < DEPTH_LIMIT + 3; i++) begin
			if ($urandom_range(0, 3) == 0) begin
				feed_string();
				feed_byte(jsi_pkg::CH_COLON);
			end
			feed_byte(opener());
		end
		for (i = 0; i < 2 * DEPTH_LIMIT + 3; i++) begin
			feed_byte(closer());
			if ($urandom_range(0, 3) == 0)
				feed_byte(jsi_pkg::CH_COMMA);
		end
		while (nest_level < 0)
			feed_byte(opener());

		in_ch.valid <= 1'b0;
		while (pending_output.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);

		$display("covered %0d input bytes, %0d output bytes, depth from %0d to %0d",
			bytes_in, bytes_out, low_depth, peak_depth);
		$display("strings, escapes, noise, a long output stall and depth saturation (%s)",
			sat_seen ? "reached" : "not reached");
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
